// ===== rtl/prl_pkg.sv =====
package prl_pkg;

  localparam int unsigned IdW    = 56;
  localparam int unsigned NameAW = 64;
  localparam int unsigned NameBW = 64;
  localparam int unsigned NameCW = 24;
  localparam int unsigned PriceW = 16;
  localparam int unsigned RecW   = IdW + NameAW + NameBW + NameCW + PriceW;

  typedef enum logic [2:0] {
    CMD_CLEAR  = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_DELETE = 3'd2,
    CMD_FIND   = 3'd3,
    CMD_READ   = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_POS  = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOT_FND  = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]  command;
    logic [7:0]  position;
    logic [55:0] record_id;
    logic [63:0] name_word0;
    logic [63:0] name_word1;
    logic [23:0] name_word2;
    logic [15:0] price;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  found_position;
    logic [55:0] out_id;
    logic [63:0] out_name0;
    logic [63:0] out_name1;
    logic [23:0] out_name2;
    logic [15:0] out_price;
    logic [7:0]  entry_count;
  } rsp_t;

  typedef struct packed {
    logic [55:0] id;
    logic [63:0] name0;
    logic [63:0] name1;
    logic [23:0] name2;
    logic [15:0] price;
  } rec_t;

  // controller to datapath
  typedef struct packed {
    logic       keep;      // capture the read record for the result
    logic       wr_en;     // write wr_data at wr_addr
    logic       wr_new;    // write the request record instead of the read data
    logic       latch_req; // capture the request
    logic       emit;      // drive one result
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic id_hit;
    logic name_hit;
  } dp_stat_t;

endpackage

// ===== rtl/prl_ram.sv =====
module prl_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== rtl/prl_datapath.sv =====
module prl_datapath import prl_pkg::*; #(
  parameter int unsigned Capacity = 128
) (
  input  logic                        clk_i,
  input  dp_cmd_t                     cmd_i,
  input  req_t                        req_i,
  input  logic [$clog2(Capacity)-1:0] rd_addr_i,
  input  logic [$clog2(Capacity)-1:0] wr_addr_i,
  input  logic [1:0]                  status_i,
  input  logic [7:0]                  pos_i,
  input  logic                        show_i,
  input  logic [7:0]                  count_i,
  output req_t                        req_o,
  output dp_stat_t                    stat_o,
  output rsp_t                        rsp_o
);

  req_t req_q;
  rec_t hold_q;
  rec_t rd_rec, new_rec, wr_rec, show_rec;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_req) begin
      req_q <= req_i;
    end
  end
  assign req_o = req_q;

  assign new_rec = '{id: req_q.record_id, name0: req_q.name_word0, name1: req_q.name_word1,
                     name2: req_q.name_word2, price: req_q.price};
  assign wr_rec  = cmd_i.wr_new ? new_rec : rd_rec;

  // record memory
  prl_ram #(.Width(RecW), .Depth(Capacity)) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.wr_en),
    .waddr_i(wr_addr_i),
    .wdata_i(wr_rec),
    .raddr_i(rd_addr_i),
    .rdata_o(rd_rec)
  );

  // key compare on the registered read data
  assign stat_o.id_hit   = rd_rec.id == req_q.record_id;
  assign stat_o.name_hit = rd_rec.name0 == req_q.name_word0 &&
                           rd_rec.name1 == req_q.name_word1 &&
                           rd_rec.name2 == req_q.name_word2;

  // affected record, held across the delete shift
  always_ff @(posedge clk_i) begin
    if (cmd_i.keep) begin
      hold_q <= rd_rec;
    end
  end

  // insert shows the new record, others the held one
  assign show_rec = (req_q.command == CMD_INSERT) ? new_rec : hold_q;

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      rsp_o.status         <= status_i;
      rsp_o.found_position <= show_i ? pos_i : 8'd0;
      rsp_o.out_id         <= show_i ? show_rec.id : '0;
      rsp_o.out_name0      <= show_i ? show_rec.name0 : '0;
      rsp_o.out_name1      <= show_i ? show_rec.name1 : '0;
      rsp_o.out_name2      <= show_i ? show_rec.name2 : '0;
      rsp_o.out_price      <= show_i ? show_rec.price : '0;
      rsp_o.entry_count    <= count_i;
    end
  end

endmodule

// ===== rtl/prl_ctrl.sv =====
module prl_ctrl import prl_pkg::*; #(
  parameter int unsigned Capacity = 128
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  req_t                        req_q_i,
  input  dp_stat_t                    stat_i,
  output logic                        busy_o,
  output dp_cmd_t                     cmd_o,
  output logic [$clog2(Capacity)-1:0] rd_addr_o,
  output logic [$clog2(Capacity)-1:0] wr_addr_o,
  output logic [1:0]                  status_o,
  output logic [7:0]                  pos_o,
  output logic                        show_o,
  output logic [7:0]                  count_o,
  output logic                        strobe_o
);

  localparam int unsigned AW = $clog2(Capacity);
  localparam int unsigned CW = $clog2(Capacity + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_DECIDE, S_SEARCH, S_INS_SHIFT, S_DEL_SHIFT, S_READ, S_EMIT
  } state_e;

  state_e         state_q;
  logic [CW-1:0]  cnt_q;     // records held
  logic [CW-1:0]  k_q;       // scan / shift index
  logic           pend_q;    // read issued last cycle
  logic [1:0]     status_q;
  logic [7:0]     pos_q;
  logic           show_q;
  logic           strobe_q;
  logic [CW-1:0]  rd_idx;
  logic [CW-1:0]  ins_slot;
  logic           hit;

  assign ins_slot = CW'(req_q_i.position) - CW'(1);
  assign hit = (req_q_i.command == CMD_DELETE) ? stat_i.id_hit : stat_i.name_hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      k_q      <= '0;
      pend_q   <= 1'b0;
      status_q <= ST_OK;
      pos_q    <= '0;
      show_q   <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= 1'b0;
      pend_q   <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start_i) state_q <= S_DECIDE;
        end
        S_DECIDE: begin
          status_q <= ST_OK;
          show_q   <= 1'b0;
          k_q      <= '0;
          state_q  <= S_EMIT;
          case (req_q_i.command)
            CMD_CLEAR: cnt_q <= '0;
            CMD_INSERT: begin
              if (req_q_i.position == 8'd0 ||
                  {1'b0, req_q_i.position} > 9'(cnt_q) + 9'd1) begin
                status_q <= ST_BAD_POS;
              end else if (cnt_q >= CW'(Capacity)) begin
                status_q <= ST_FULL;
              end else begin
                k_q     <= cnt_q;
                pos_q   <= req_q_i.position;
                show_q  <= 1'b1;
                state_q <= S_INS_SHIFT;
              end
            end
            CMD_DELETE, CMD_FIND: begin
              if (cnt_q == '0) status_q <= ST_NOT_FND;
              else state_q <= S_SEARCH;
            end
            CMD_READ: begin
              if (req_q_i.position == 8'd0 || 9'(req_q_i.position) > 9'(cnt_q)) begin
                status_q <= ST_BAD_POS;
              end else begin
                pos_q   <= req_q_i.position;
                show_q  <= 1'b1;
                state_q <= S_READ;
              end
            end
            default: ;
          endcase
        end
        S_SEARCH: begin
          // read k each cycle, compare the registered data in the next cycle
          if (pend_q && hit) begin
            pos_q  <= 8'(k_q);
            show_q <= 1'b1;
            if (req_q_i.command == CMD_DELETE) begin
              state_q <= S_DEL_SHIFT;
              pend_q  <= 1'b0;
            end else begin
              state_q <= S_EMIT;
            end
          end else if (k_q == cnt_q) begin
            status_q <= ST_NOT_FND;
            state_q  <= S_EMIT;
          end else begin
            k_q    <= k_q + CW'(1);
            pend_q <= 1'b1;
          end
        end
        S_INS_SHIFT: begin
          // move slot k-1 to k, from the top down
          if (pend_q) begin
            k_q <= k_q - CW'(1);
          end
          if (k_q == ins_slot && !pend_q) begin
            cnt_q   <= cnt_q + CW'(1);
            state_q <= S_EMIT;
          end else if (!pend_q) begin
            pend_q <= 1'b1;
          end
        end
        S_DEL_SHIFT: begin
          // pos_q is the found slot plus one; move slot k to k-1
          if (pend_q) begin
            k_q <= k_q + CW'(1);
          end
          if (k_q == cnt_q && !pend_q) begin
            cnt_q   <= cnt_q - CW'(1);
            state_q <= S_EMIT;
          end else if (!pend_q) begin
            pend_q <= 1'b1;
          end
        end
        S_READ: begin
          if (pend_q) state_q <= S_EMIT;
          else pend_q <= 1'b1;
        end
        S_EMIT: begin
          strobe_q <= 1'b1;
          state_q  <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // read address per state
  always_comb begin
    rd_idx = '0;
    case (state_q)
      S_SEARCH: begin
        rd_idx = k_q;
      end
      S_INS_SHIFT: begin
        rd_idx = k_q - CW'(1);
      end
      S_DEL_SHIFT: begin
        rd_idx = k_q;
      end
      S_READ: begin
        rd_idx = ins_slot;
      end
      default: ;
    endcase
  end

  // datapath commands per state; the affected record is kept when it is read
  always_comb begin
    cmd_o.keep      = pend_q && ((state_q == S_SEARCH && hit) || state_q == S_READ);
    cmd_o.latch_req = (state_q == S_IDLE) && start_i;
    cmd_o.emit      = state_q == S_EMIT;
    cmd_o.wr_en     = 1'b0;
    cmd_o.wr_new    = 1'b0;
    wr_addr_o       = '0;
    case (state_q)
      S_INS_SHIFT: begin
        if (pend_q) begin
          cmd_o.wr_en = 1'b1;
          wr_addr_o   = AW'(k_q);
        end else if (k_q == ins_slot) begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.wr_new = 1'b1;
          wr_addr_o    = AW'(k_q);
        end
      end
      S_DEL_SHIFT: begin
        if (pend_q) begin
          cmd_o.wr_en = 1'b1;
          wr_addr_o   = AW'(k_q - CW'(1));
        end
      end
      default: ;
    endcase
  end

  assign rd_addr_o = AW'(rd_idx);
  assign busy_o    = state_q != S_IDLE;
  assign status_o  = status_q;
  assign pos_o     = pos_q;
  assign show_o    = show_q;
  assign count_o   = 8'(cnt_q);
  assign strobe_o  = strobe_q;

  // the search read issued in S_SEARCH compares against k_q (already advanced)
  // so pos_q = k_q is 1-based; delete then starts shifting at k_q = pos_q

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CW'(Capacity))
    else $error("count above capacity");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_q |-> state_q == S_IDLE)
    else $error("result outside idle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |=> strobe_q)
    else $error("missing result strobe");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.wr_en && state_q == S_DEL_SHIFT) |-> k_q != '0)
    else $error("delete shift below zero");

endmodule

// ===== rtl/positional_record_list.sv =====
// channel   ports                       dir  notes
// command   start_i, busy_o, cmd_i      in   taken when start_i && !busy_o
// result    done_o, rsp_o               out  one cycle pulse, no backpressure
//
// busy_o is high while a command runs, also for clear, unknown and rejected commands;
// find and delete scan one record per cycle;
// insert and delete shift one record at a time, each read and then written one slot on.
// done_o pulses in the same cycle that busy_o falls; a new item can be taken then.
// rst_ni clears the count and control; memory contents are left as they are.
module positional_record_list import prl_pkg::*; #(
  parameter int unsigned CAPACITY = 128
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  req_t cmd_i,
  output logic busy_o,
  output logic done_o,
  output rsp_t rsp_o
);

  localparam int unsigned AW = $clog2(CAPACITY);

  dp_cmd_t        dp_cmd;
  dp_stat_t       dp_stat;
  req_t           req_q;
  logic [AW-1:0]  rd_addr, wr_addr;
  logic [1:0]     status;
  logic [7:0]     pos, count;
  logic           show, strobe;

  prl_ctrl #(.Capacity(CAPACITY)) u_ctrl (
    .clk_i, .rst_ni, .start_i,
    .req_q_i  (req_q),
    .stat_i   (dp_stat),
    .busy_o,
    .cmd_o    (dp_cmd),
    .rd_addr_o(rd_addr),
    .wr_addr_o(wr_addr),
    .status_o (status),
    .pos_o    (pos),
    .show_o   (show),
    .count_o  (count),
    .strobe_o (strobe)
  );

  prl_datapath #(.Capacity(CAPACITY)) u_dp (
    .clk_i,
    .cmd_i    (dp_cmd),
    .req_i    (cmd_i),
    .rd_addr_i(rd_addr),
    .wr_addr_i(wr_addr),
    .status_i (status),
    .pos_i    (pos),
    .show_i   (show),
    .count_i  (count),
    .req_o    (req_q),
    .stat_o   (dp_stat),
    .rsp_o
  );

  assign done_o = strobe;

endmodule

// ===== dv/tb_positional_record_list.sv =====
`timescale 1ns / 1ps

module tb_positional_record_list;
  import prl_pkg::*;

  localparam int unsigned Cap        = 128;
  localparam int unsigned NumItems   = 1850;
  localparam int unsigned CycleLimit = 4_000_000;

  // scoreboard: shadow record table and queue of expected responses
  class record_list_sb;
    rec_t        table_q[Cap];
    int unsigned fill;
    rsp_t        rsp_q[$];
    int unsigned errors;
    int unsigned matched;

    function new();
      fill = 0;
      errors = 0;
      matched = 0;
    endfunction

    function rsp_t slot_rsp(int unsigned slot);
      rsp_t r;
      r = '0;
      r.status         = ST_OK;
      r.found_position = 8'(slot + 1);
      r.out_id         = table_q[slot].id;
      r.out_name0      = table_q[slot].name0;
      r.out_name1      = table_q[slot].name1;
      r.out_name2      = table_q[slot].name2;
      r.out_price      = table_q[slot].price;
      return r;
    endfunction

    // apply one accepted item to the shadow table and queue its response
    function void note_item(req_t q);
      rsp_t        e;
      int unsigned k;
      int unsigned p;
      e = '0;
      p = q.position;
      case (q.command)
        CMD_CLEAR: fill = 0;
        CMD_INSERT: begin
          if (p < 1 || p > fill + 1) e.status = ST_BAD_POS;
          else if (fill >= Cap) e.status = ST_FULL;
          else begin
            for (k = fill; k > p - 1; k--) table_q[k] = table_q[k-1];
            table_q[p-1] = '{q.record_id, q.name_word0, q.name_word1,
                             q.name_word2, q.price};
            fill++;
            e = slot_rsp(p - 1);
          end
        end
        CMD_DELETE: begin
          for (k = 0; k < fill; k++) if (table_q[k].id == q.record_id) break;
          if (k == fill) e.status = ST_NOT_FND;
          else begin
            e = slot_rsp(k);
            for (; k + 1 < fill; k++) table_q[k] = table_q[k+1];
            fill--;
          end
        end
        CMD_FIND: begin
          for (k = 0; k < fill; k++)
            if (table_q[k].name0 == q.name_word0 && table_q[k].name1 == q.name_word1 &&
                table_q[k].name2 == q.name_word2) break;
          if (k == fill) e.status = ST_NOT_FND;
          else e = slot_rsp(k);
        end
        CMD_READ: begin
          if (p < 1 || p > fill) e.status = ST_BAD_POS;
          else e = slot_rsp(p - 1);
        end
        default: ;
      endcase
      e.entry_count = 8'(fill);
      rsp_q.push_back(e);
    endfunction

    function void field_cmp(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
        errors++;
        $display("%0t: mismatch %s expected %h actual %h", $time, name, exp_v, act_v);
      end
    endfunction

    // compare one response with the oldest expectation
    function void check_result(rsp_t a);
      rsp_t e;
      if (rsp_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected response, expected none actual %h", $time, a);
        return;
      end
      e = rsp_q.pop_front();
      matched++;
      field_cmp("status", 64'(e.status), 64'(a.status));
      field_cmp("found_position", 64'(e.found_position), 64'(a.found_position));
      field_cmp("out_id", 64'(e.out_id), 64'(a.out_id));
      field_cmp("out_name0", e.out_name0, a.out_name0);
      field_cmp("out_name1", e.out_name1, a.out_name1);
      field_cmp("out_name2", 64'(e.out_name2), 64'(a.out_name2));
      field_cmp("out_price", 64'(e.out_price), 64'(a.out_price));
      field_cmp("entry_count", 64'(e.entry_count), 64'(a.entry_count));
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  req_t cmd_i = '0;
  logic busy_o;
  logic done_o;
  rsp_t rsp_o;

  record_list_sb sb = new();
  int unsigned   cycles = 0;
  int unsigned   items_sent = 0;
  bit            idle_on = 1'b1;
  int unsigned   full_hits = 0;

  positional_record_list #(.CAPACITY(Cap)) uut (
    .clk_i, .rst_ni, .start_i, .cmd_i, .busy_o, .done_o, .rsp_o
  );

  always #1 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("TB_ERROR");
      $finish;
    end
  end

  // response monitor
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (sb.rsp_q.size() > 0 && sb.rsp_q[0].status == ST_FULL) full_hits++;
      sb.check_result(rsp_o);
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // drive one item and wait for it to be taken; sometimes a random gap first
  task automatic send_item(req_t q);
    int unsigned gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_i <= 1'b1;
    cmd_i   <= q;
    forever begin
      @(posedge clk_i);
      if (!busy_o) break;
    end
    sb.note_item(q);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic go_quiet();
    start_i <= 1'b0;
    while (sb.rsp_q.size() != 0) @(negedge clk_i);
  endtask

  function automatic req_t mk(logic [2:0] c, int unsigned p, logic [55:0] id,
                              logic [63:0] n0, logic [63:0] n1, logic [23:0] n2,
                              logic [15:0] pr);
    req_t q;
    q = '{c, 8'(p), id, n0, n1, n2, pr};
    return q;
  endfunction

  // random item; grow favors inserts, shrink favors deletes of held ids
  function automatic req_t rand_item(int unsigned mode);
    req_t        q;
    int unsigned r;
    int unsigned pick;
    q.record_id  = 56'(rand64());
    q.name_word0 = rand64();
    q.name_word1 = rand64();
    q.name_word2 = 24'($urandom);
    q.price      = 16'($urandom);
    if ($urandom_range(0, 3) == 0) begin
      q.name_word1 = '0;
      q.name_word2 = '0;
    end
    r = $urandom_range(0, 99);
    case (mode)
      0: q.command = (r < 80) ? CMD_INSERT : (r < 90) ? CMD_READ : CMD_FIND;
      1: q.command = (r < 65) ? CMD_DELETE : (r < 80) ? CMD_FIND : CMD_READ;
      default: q.command = (r < 30) ? CMD_INSERT : (r < 55) ? CMD_DELETE :
                           (r < 75) ? CMD_FIND : (r < 95) ? CMD_READ :
                           (r < 97) ? CMD_CLEAR : 3'($urandom_range(5, 7));
    endcase
    // usually a legal position, sometimes anything
    if ($urandom_range(0, 9) == 0) q.position = 8'($urandom);
    else if (q.command == CMD_INSERT) q.position = 8'($urandom_range(1, sb.fill + 1));
    else q.position = 8'($urandom_range(1, (sb.fill == 0) ? 1 : sb.fill));
    // keys mostly taken from held records so searches hit
    if (sb.fill > 0 && $urandom_range(0, 9) < 7) begin
      pick = $urandom_range(0, sb.fill - 1);
      q.record_id  = sb.table_q[pick].id;
      q.name_word0 = sb.table_q[pick].name0;
      q.name_word1 = sb.table_q[pick].name1;
      q.name_word2 = sb.table_q[pick].name2;
    end
    return q;
  endfunction

  initial begin
    int unsigned mode;
    int unsigned k;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: empty table, bad positions, extremes, every command
    send_item(mk(CMD_READ, 1, '0, '0, '0, '0, '0));
    send_item(mk(CMD_DELETE, 0, 56'h1, '0, '0, '0, '0));
    send_item(mk(CMD_FIND, 0, '0, '0, '0, '0, '0));
    send_item(mk(CMD_INSERT, 0, 56'h5, 64'h1, '0, '0, 16'h1));
    send_item(mk(CMD_INSERT, 2, 56'h5, 64'h1, '0, '0, 16'h1));
    send_item(mk(CMD_INSERT, 1, '1, '1, '1, '1, '1));
    send_item(mk(CMD_INSERT, 1, '0, '0, '0, '0, '0));
    send_item(mk(CMD_INSERT, 3, 56'h41, 64'h41, '0, '0, 16'h8000));
    send_item(mk(CMD_INSERT, 2, 56'h41, 64'h42, '0, 24'h43, 16'h7));
    send_item(mk(CMD_READ, 1, '0, '0, '0, '0, '0));
    send_item(mk(CMD_READ, 4, '0, '0, '0, '0, '0));
    send_item(mk(CMD_READ, 5, '0, '0, '0, '0, '0));
    send_item(mk(CMD_READ, 255, '0, '0, '0, '0, '0));
    send_item(mk(CMD_FIND, 0, '0, 64'h41, '0, '0, '0));
    send_item(mk(CMD_FIND, 0, '0, 64'h41, '0, 24'h1, '0));
    send_item(mk(CMD_DELETE, 0, 56'h41, '0, '0, '0, '0));
    send_item(mk(CMD_DELETE, 0, 56'h99, '0, '0, '0, '0));
    send_item(mk(3'd5, 1, '1, '1, '1, '1, '1));
    send_item(mk(3'd6, 0, '0, '0, '0, '0, '0));
    send_item(mk(3'd7, 2, '0, '0, '0, '0, '0));
    send_item(mk(CMD_CLEAR, 0, '0, '0, '0, '0, '0));
    send_item(mk(CMD_READ, 1, '0, '0, '0, '0, '0));

    // fill to capacity, then overflow and bad position on a full table
    for (k = 0; k < Cap; k++) begin
      send_item(mk(CMD_INSERT, $urandom_range(1, sb.fill + 1), 56'(rand64()),
                   rand64(), rand64(), 24'($urandom), 16'($urandom)));
    end
    send_item(mk(CMD_INSERT, Cap + 1, '1, '1, '1, '1, '1));
    send_item(mk(CMD_INSERT, 1, '1, '1, '1, '1, '1));
    send_item(mk(CMD_INSERT, Cap + 2, '1, '1, '1, '1, '1));
    send_item(mk(CMD_READ, Cap, '0, '0, '0, '0, '0));
    send_item(mk(CMD_DELETE, 0, sb.table_q[Cap-1].id, '0, '0, '0, '0));

    // hold off until the block has drained everything
    go_quiet();
    repeat ($urandom_range(3, 20)) @(negedge clk_i);

    // random phases
    while (items_sent < NumItems) begin
      mode = $urandom_range(0, 2);
      if (items_sent > NumItems - 200) idle_on = 1'b0;
      for (k = 0; k < 100 && items_sent < NumItems; k++) send_item(rand_item(mode));
    end

    start_i <= 1'b0;
    while (sb.rsp_q.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);

    $display("sent %0d items, checked %0d responses, %0d table-full responses",
             items_sent, sb.matched, full_hits);
    $display("covered clear, insert, delete, find, read, unknown commands and bad positions");
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== positional_record_list.f =====
rtl/prl_pkg.sv
rtl/prl_ram.sv
rtl/prl_datapath.sv
rtl/prl_ctrl.sv
rtl/positional_record_list.sv
dv/tb_positional_record_list.sv
